// ----- hdl/slod_pkg.sv -----
// Package with constants and register indexes for the screen size LOD selector.
package slod_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_LEVELS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 32;
  localparam int LVL_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [WORD_W-1:0] NEAR_LIMIT = 32'd7;
  localparam logic [WORD_W-1:0] TAN_MIN    = 32'd7;
  localparam logic [WORD_W-1:0] SIZE_MAX   = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ONE_Q      = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS  = 3'd0,
    REG_TAN     = 3'd1,
    REG_CULL    = 3'd2,
    REG_COUNT   = 3'd3,
    REG_THRESH0 = 3'd4,
    REG_THRESH1 = 3'd5,
    REG_THRESH2 = 3'd6,
    REG_THRESH3 = 3'd7
  } cfg_idx_t;

endpackage

// ----- hdl/screen_size_lod_selector_top.sv -----
// Top level of the screen size LOD selector: a fully pipelined distance, size and level datapath.
//
// Usage: drive the nine position and scale inputs and raise in_start; an input word
// is taken at every rising edge with in_start high and in_busy low. in_busy is
// always low, so a new word can enter in every cycle.
// Each word gives exactly one result word, shown on the out_ ports for one cycle
// with out_valid high after it has passed the difference, square, sum, square
// root, multiply, division and output registers. One word enters and one leaves
// per cycle. The depth is set by the square root (one result bit per stage, 34
// stages) and the divider (one quotient bit per stage, 32 stages).
// The receiver cannot hold results off; it must take each word as it appears.
// Configuration is written through cfg_we, cfg_idx and cfg_wdata while no word is
// in flight; the registers are read live by the pipeline.
// Reset, synchronous and active low, clears all valid bits and sets the
// registers to their defaults: radius and tangent 1.0, everything else zero.
module screen_size_lod_selector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_start,
  output logic                          in_busy,
  input  logic signed [31:0]            in_obj_x,
  input  logic signed [31:0]            in_obj_y,
  input  logic signed [31:0]            in_obj_z,
  input  logic signed [31:0]            in_cam_x,
  input  logic signed [31:0]            in_cam_y,
  input  logic signed [31:0]            in_cam_z,
  input  logic signed [31:0]            in_scale_x,
  input  logic signed [31:0]            in_scale_y,
  input  logic signed [31:0]            in_scale_z,
  input  logic                          cfg_we,
  input  logic [slod_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [slod_pkg::WORD_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic                          out_updated,
  output logic                          out_culled,
  output logic [slod_pkg::LVL_W-1:0]    out_level_index,
  output logic [slod_pkg::WORD_W-1:0]   out_screen_size
);
  import slod_pkg::*;

  localparam int SQ_STEPS = 34;
  localparam int DIV_STEPS = 32;
  localparam int RS_W = 64;
  localparam int NUM_W = RS_W + FRAC_BITS;
  localparam int DEN_W = 66;
  localparam int CMP_W = DEN_W + DIV_STEPS;

  logic [31:0] radius_r, tan_r, cull_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0] thr_r [0:MAX_LEVELS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ONE_Q;
      tan_r    <= ONE_Q;
      cull_r   <= '0;
      count_r  <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) thr_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_RADIUS:  radius_r <= cfg_wdata;
        REG_TAN:     tan_r    <= cfg_wdata;
        REG_CULL:    cull_r   <= cfg_wdata;
        REG_COUNT:   count_r  <= cfg_wdata[CNT_W-1:0];
        REG_THRESH0: thr_r[0] <= cfg_wdata;
        REG_THRESH1: thr_r[1] <= cfg_wdata;
        REG_THRESH2: thr_r[2] <= cfg_wdata;
        REG_THRESH3: thr_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_busy = 1'b0;

  logic [CNT_W-1:0] count_eff;
  logic [31:0] tan_eff;
  assign count_eff = (count_r > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : count_r;
  assign tan_eff = (tan_r < TAN_MIN) ? TAN_MIN : tan_r;

  // Stage 1: differences and largest scale magnitude.
  logic v1_r;
  logic [32:0] dx_r, dy_r, dz_r;
  logic [31:0] smax_r;
  logic [32:0] dx_nxt, dy_nxt, dz_nxt;
  logic [31:0] ax, ay, az, smax_nxt;

  function automatic logic [32:0] mag_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  always_comb begin
    dx_nxt = mag_diff(in_obj_x, in_cam_x);
    dy_nxt = mag_diff(in_obj_y, in_cam_y);
    dz_nxt = mag_diff(in_obj_z, in_cam_z);
    ax = mag32(in_scale_x);
    ay = mag32(in_scale_y);
    az = mag32(in_scale_z);
    smax_nxt = ax;
    if (ay > smax_nxt) smax_nxt = ay;
    if (az > smax_nxt) smax_nxt = az;
  end

  // Stage 2: squares.
  logic v2_r;
  logic [65:0] qx_r, qy_r, qz_r;
  logic [31:0] smax2_r;

  // Stage 3: sum of squares and radius times scale.
  logic [67:0] sq_x_r [0:SQ_STEPS];
  logic [33:0] root_r [0:SQ_STEPS];
  logic [35:0] rem_r  [0:SQ_STEPS];
  logic [RS_W-1:0] rs_r [0:SQ_STEPS];
  logic sv_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      sv_r[0] <= 1'b0;
    end else begin
      v1_r <= in_start;
      v2_r <= v1_r;
      sv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dz_r <= dz_nxt;
    smax_r <= smax_nxt;
    qx_r <= 66'(dx_r) * 66'(dx_r);
    qy_r <= 66'(dy_r) * 66'(dy_r);
    qz_r <= 66'(dz_r) * 66'(dz_r);
    smax2_r <= smax_r;
    sq_x_r[0] <= 68'(qx_r) + 68'(qy_r) + 68'(qz_r);
    root_r[0] <= '0;
    rem_r[0] <= '0;
    rs_r[0] <= RS_W'(radius_r) * RS_W'(smax2_r);
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int P = SQ_STEPS - 1 - j;
    logic [37:0] rem_w, trial_w;
    assign rem_w = {rem_r[j], sq_x_r[j][2*P+1 -: 2]};
    assign trial_w = {2'b00, root_r[j], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j+1] <= 1'b0;
      else sv_r[j+1] <= sv_r[j];
    end

    always_ff @(posedge clk) begin
      sq_x_r[j+1] <= sq_x_r[j];
      rs_r[j+1] <= rs_r[j];
      if (rem_w >= trial_w) begin
        rem_r[j+1] <= 36'(rem_w - trial_w);
        root_r[j+1] <= {root_r[j][32:0], 1'b1};
      end else begin
        rem_r[j+1] <= 36'(rem_w);
        root_r[j+1] <= {root_r[j][32:0], 1'b0};
      end
    end
  end

  // Multiply stage: numerator and denominator of the size.
  logic vm_r, near_m_r;
  logic [NUM_W-1:0] num_m_r;
  logic [DEN_W-1:0] den_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else vm_r <= sv_r[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    near_m_r <= (root_r[SQ_STEPS] <= 34'(NEAR_LIMIT));
    num_m_r <= {rs_r[SQ_STEPS], {FRAC_BITS{1'b0}}};
    den_m_r <= DEN_W'(root_r[SQ_STEPS]) * DEN_W'(tan_eff);
  end

  // Saturation check and restoring division, one quotient bit per stage.
  logic [NUM_W-1:0] n_r [0:DIV_STEPS];
  logic [DEN_W-1:0] d_r [0:DIV_STEPS];
  logic [31:0] q_r [0:DIV_STEPS];
  logic sat_r [0:DIV_STEPS];
  logic near_r [0:DIV_STEPS];
  logic dv_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else dv_r[0] <= vm_r;
  end

  always_ff @(posedge clk) begin
    n_r[0] <= num_m_r;
    d_r[0] <= den_m_r;
    q_r[0] <= '0;
    near_r[0] <= near_m_r;
    sat_r[0] <= (CMP_W'(num_m_r) >= {den_m_r, 32'd0});
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int B = DIV_STEPS - 1 - i;
    logic [CMP_W-1:0] t_w;
    logic ge_w;
    assign t_w = CMP_W'(d_r[i]) << B;
    assign ge_w = CMP_W'(n_r[i]) >= t_w;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else dv_r[i+1] <= dv_r[i];
    end

    always_ff @(posedge clk) begin
      d_r[i+1] <= d_r[i];
      sat_r[i+1] <= sat_r[i];
      near_r[i+1] <= near_r[i];
      if (ge_w) begin
        n_r[i+1] <= NUM_W'(CMP_W'(n_r[i]) - t_w);
        q_r[i+1] <= q_r[i] | (32'd1 << B);
      end else begin
        n_r[i+1] <= n_r[i];
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // Output stage: culling and level selection.
  logic upd_nxt, cul_nxt;
  logic [LVL_W-1:0] lvl_nxt;
  logic [31:0] size_nxt, size_w;
  logic found;

  always_comb begin
    size_w = sat_r[DIV_STEPS] ? SIZE_MAX : q_r[DIV_STEPS];
    upd_nxt = 1'b0;
    cul_nxt = 1'b0;
    lvl_nxt = '0;
    size_nxt = '0;
    found = 1'b0;
    if (count_eff != '0) begin
      upd_nxt = 1'b1;
      if (near_r[DIV_STEPS]) begin
        size_nxt = SIZE_MAX;
      end else begin
        size_nxt = size_w;
        if (cull_r != '0 && size_w < cull_r) begin
          cul_nxt = 1'b1;
        end else begin
          lvl_nxt = LVL_W'(count_eff - CNT_W'(1));
          for (int k = 0; k < MAX_LEVELS; k++) begin
            if (!found && CNT_W'(k) < count_eff && size_w >= thr_r[k]) begin
              lvl_nxt = LVL_W'(k);
              found = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= dv_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    out_updated <= upd_nxt;
    out_culled <= cul_nxt;
    out_level_index <= lvl_nxt;
    out_screen_size <= size_nxt;
  end

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_updated |-> !out_culled && out_level_index == '0
                                  && out_screen_size == '0)
    else $error("result without selection carries nonzero fields");

  a_cull_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_culled |-> out_updated && out_level_index == '0)
    else $error("culled result with a level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated && !out_culled |-> CNT_W'(out_level_index) < count_eff)
    else $error("level beyond levels in use");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

// ----- tb/screen_size_lod_selector_top_tb.sv -----
// Self-checking testbench for the screen size LOD selector top level.
`timescale 1ns / 100ps

module screen_size_lod_selector_top_tb;
  import slod_pkg::*;

  localparam int LATENCY = 72;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [31:0] word_t;
  typedef word_t item_t [9];

  typedef struct packed {
    logic        updated;
    logic        culled;
    logic [1:0]  level;
    logic [31:0] size;
  } lod_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic in_busy;
  word_t in_obj_x = '0, in_obj_y = '0, in_obj_z = '0;
  word_t in_cam_x = '0, in_cam_y = '0, in_cam_z = '0;
  word_t in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = REG_RADIUS;
  word_t cfg_wdata = '0;
  logic out_valid, out_updated, out_culled;
  logic [1:0] out_level_index;
  word_t out_screen_size;

  word_t radius_q = ONE_Q, tan_q = ONE_Q, cull_q = '0;
  logic [2:0] count_q = '0;
  word_t thresh_q [4] = '{default: '0};

  lod_result_t pending_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int gap_pct = 0;

  screen_size_lod_selector_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_obj_x(in_obj_x), .in_obj_y(in_obj_y), .in_obj_z(in_obj_z),
    .in_cam_x(in_cam_x), .in_cam_y(in_cam_y), .in_cam_z(in_cam_z),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y), .in_scale_z(in_scale_z),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_updated(out_updated), .out_culled(out_culled),
    .out_level_index(out_level_index), .out_screen_size(out_screen_size)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("screen_size_lod_selector_top test failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [32:0] abs_diff(input word_t a, input word_t b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic lod_result_t select_level(input item_t v);
    lod_result_t r;
    logic [2:0] n;
    logic [32:0] d0, d1, d2, s, m;
    logic [67:0] sum;
    logic [34:0] root, trial;
    logic [127:0] num, den;
    r = '0;
    n = (count_q > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : count_q;
    if (n == 0) return r;
    r.updated = 1'b1;
    d0 = abs_diff(v[0], v[3]);
    d1 = abs_diff(v[1], v[4]);
    d2 = abs_diff(v[2], v[5]);
    sum = 68'(d0) * 68'(d0) + 68'(d1) * 68'(d1) + 68'(d2) * 68'(d2);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (35'd1 << b);
      if (70'(trial) * 70'(trial) <= 70'(sum)) root = trial;
    end
    if (root <= 35'(NEAR_LIMIT)) begin
      r.size = SIZE_MAX;
      return r;
    end
    s = '0;
    for (int k = 6; k < 9; k++) begin
      m = v[k][31] ? 33'(-$signed({v[k][31], v[k]})) : 33'(v[k]);
      if (m > s) s = m;
    end
    num = (128'(radius_q) * 128'(s)) << FRAC_BITS;
    den = 128'(root) * 128'((tan_q < TAN_MIN) ? TAN_MIN : tan_q);
    r.size = (num >= (den << 32)) ? SIZE_MAX : 32'(num / den);
    if (cull_q != 0 && r.size < cull_q) begin
      r.culled = 1'b1;
      return r;
    end
    r.level = 2'(n - 1);
    for (int i = n - 1; i >= 0; i--)
      if (r.size >= thresh_q[i]) r.level = 2'(i);
    return r;
  endfunction

  always @(posedge clk) begin
    lod_result_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (out_updated !== want.updated)
          report($sformatf("updated %b, expected %b", out_updated, want.updated));
        if (out_culled !== want.culled)
          report($sformatf("culled %b, expected %b", out_culled, want.culled));
        if (out_level_index !== want.level)
          report($sformatf("level %0d, expected %0d", out_level_index, want.level));
        if (out_screen_size !== want.size)
          report($sformatf("size %h, expected %h", out_screen_size, want.size));
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_item(input item_t v);
    if ($urandom_range(99) < gap_pct) begin
      in_start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    {in_obj_x, in_obj_y, in_obj_z} = {v[0], v[1], v[2]};
    {in_cam_x, in_cam_y, in_cam_z} = {v[3], v[4], v[5]};
    {in_scale_x, in_scale_y, in_scale_z} = {v[6], v[7], v[8]};
    in_start = 1'b1;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    pending_q = {pending_q, select_level(v)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RADIUS: radius_q = val;
      REG_TAN:    tan_q = val;
      REG_CULL:   cull_q = val;
      REG_COUNT:  count_q = val[2:0];
      default:    thresh_q[idx - REG_THRESH0] = val;
    endcase
  endtask

  task automatic set_config(input word_t r, input word_t t, input word_t c,
                            input word_t n, input word_t t0, input word_t t1,
                            input word_t t2, input word_t t3);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_TAN, t);
    write_reg(REG_CULL, c);
    write_reg(REG_COUNT, n);
    write_reg(REG_THRESH0, t0);
    write_reg(REG_THRESH1, t1);
    write_reg(REG_THRESH2, t2);
    write_reg(REG_THRESH3, t3);
  endtask

  function automatic word_t spread_value();
    word_t w;
    w = $urandom >> $urandom_range(0, 31);
    return $urandom_range(1) ? -w : w;
  endfunction

  function automatic item_t random_item();
    item_t v;
    for (int k = 0; k < 9; k++) v[k] = $urandom;
    if ($urandom_range(99) < 80)
      for (int k = 0; k < 3; k++) v[k + 3] = v[k] + spread_value();
    if ($urandom_range(99) < 70)
      for (int k = 6; k < 9; k++) v[k] = spread_value();
    return v;
  endfunction

  task automatic random_config();
    word_t th [4];
    for (int i = 0; i < 4; i++) th[i] = $urandom >> $urandom_range(4, 28);
    if ($urandom_range(3) != 0) th.rsort();
    set_config($urandom >> $urandom_range(0, 24), $urandom >> $urandom_range(0, 24),
               $urandom_range(2) == 0 ? ($urandom >> $urandom_range(8, 30)) : 32'd0,
               $urandom_range(0, 7), th[0], th[1], th[2], th[3]);
  endtask

  task automatic test_reset_defaults();
    repeat (5) send_item(random_item());
  endtask

  task automatic test_directed();
    item_t v;
    set_config(ONE_Q, ONE_Q, 32'd0, 32'd4, 32'h0004_0000, 32'h0001_0000,
               32'h0000_4000, 32'h0000_1000);
    v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_item(v);
    v = '{default: 32'h0};
    send_item(v);
    v[0] = 32'd7; v[6] = ONE_Q;
    send_item(v);
    v[0] = 32'd8;
    send_item(v);
    v = '{32'h0001_0000, 0, 0, 0, 0, 0, ONE_Q, 32'hFFFF_0000, 32'h0000_8000};
    send_item(v);
    v[0] = 32'h0010_0000;
    send_item(v);
    v[0] = 32'h0100_0000;
    send_item(v);
    v[0] = 32'h0000_1000;
    send_item(v);
    v = '{32'h0000_0010, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0};
    send_item(v);
    set_config(32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'd7, 32'h0000_1000,
               32'h0010_0000, 32'h0000_0010, 32'hFFFF_FFFF);
    v = '{32'h0100_0000, 32'h0100_0000, 0, 0, 0, 0, 32'd1, 0, 0};
    send_item(v);
    v[6] = 32'd0;
    send_item(v);
    v[6] = 32'hFFFF_FFF0;
    send_item(v);
    v = '{32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'd1, 32'd1, 32'd1};
    send_item(v);
    set_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    v = '{32'h0001_0000, 0, 0, 0, 0, 0, ONE_Q, ONE_Q, ONE_Q};
    send_item(v);
    set_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'h1, 32'h1, 32'h0, 32'h0);
    send_item(v);
    set_config(ONE_Q, ONE_Q, 32'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(v);
  endtask

  task automatic test_random_phase(input int pct);
    gap_pct = pct;
    for (int c = 0; c < 5; c++) begin
      random_config();
      repeat (95) send_item(random_item());
    end
  endtask

  task automatic test_sender_pause();
    gap_pct = 0;
    random_config();
    repeat (20) send_item(random_item());
    in_start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) send_item(random_item());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed();
    test_random_phase(0);
    test_random_phase(64);
    test_random_phase(0);
    test_random_phase(11);
    test_sender_pause();
    in_start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("screen_size_lod_selector_top test passed");
    end else begin
      $display("screen_size_lod_selector_top test failed");
    end
    $finish;
  end

endmodule
